FILE: design/tpiq_pkg.sv
// ----------------------------------------------------------------------------
// tpiq_pkg: shared types and constants of the two priority input queue
// Operation, packet kind and status codes, register indexes, field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tpiq_pkg;

    // Fixed field widths
    localparam int DESC_W = 32;   // descriptor field on both channels
    localparam int CFG_W  = 11;   // capacity registers
    localparam int FILL_W = 11;   // fill counts in a result

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Configuration register indexes
    typedef enum logic {
        REG_HIGH_CAP = 1'b0,
        REG_LOW_CAP  = 1'b1
    } tpiq_reg_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } tpiq_func_t;

    typedef enum logic [1:0] {
        KIND_NORMAL      = 2'd0,
        KIND_RESUBMIT    = 2'd1,
        KIND_RECIRCULATE = 2'd2,
        KIND_STOP        = 2'd3
    } tpiq_kind_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_DROPPED    = 3'd1,
        ST_RETRY_FULL = 3'd2,
        ST_POPPED     = 3'd3,
        ST_EMPTY      = 3'd4
    } tpiq_status_t;

    // Queue status toward the arbiter
    typedef struct packed {
        logic full;   // fill at or above effective capacity
        logic held;   // at least one entry
    } tpiq_qstat_t;

endpackage

`default_nettype wire

FILE: design/tpiq_queue.sv
// ----------------------------------------------------------------------------
// tpiq_queue: one descriptor FIFO with a programmable capacity
// Circular store with head, tail and fill count; registered read at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module tpiq_queue
    import tpiq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [CFG_W-1:0]               capacity,
    input  wire logic                           push_en,
    input  wire logic [WIDTH-1:0]               push_data,
    input  wire logic                           pop_en,
    output tpiq_qstat_t                         stat,
    output logic      [$clog2(DEPTH+1)-1:0]     count,
    output logic      [WIDTH-1:0]               rdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [AW-1:0]    LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [WIDTH-1:0] rdata_reg;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] cap_eff;

    // Saturate the capacity to the store depth; zero means always full
    always_comb begin
        cap_ext = CMP_W'(capacity);
        cap_eff = (cap_ext > DEPTH_CMP) ? DEPTH_CMP : cap_ext;
        stat.full = CMP_W'(count_reg) >= cap_eff;
        stat.held = count_reg != '0;
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_en) begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);
            count_next = count_reg + CW'(1);
        end
        if (pop_en) begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store write and head read; read data holds until the next pop
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem[tail_reg] <= push_data;
        end
        if (pop_en) begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign count = count_reg;
    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/two_priority_input_queue.sv
// ----------------------------------------------------------------------------
// two_priority_input_queue: strict priority pair of descriptor FIFOs
// Push by packet kind into the high or low queue, pop high before low.
// ----------------------------------------------------------------------------
//  channel   direction  ports                       contents
//  s_        in         s_tvalid/s_tready/s_tdata   push or pop request
//                       s_tuser
//  m_        out        m_tvalid/m_tready/m_tdata   status, descriptor, fills
//                       m_tuser
//  cfg_      in         cfg_wr_en/cfg_index/        capacity writes
//                       cfg_wdata
//
//  One request per cycle while the result side is not stalled; its result is
//  registered and appears in the cycle after the transfer, the popped
//  descriptor coming from the queue store's registered read port. Reset clears
//  heads, tails, counts and the result slot, and loads both capacities with
//  1024; the stores are not cleared and need no sweep. s_tready is low during
//  reset, and drops while a result is held and m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module two_priority_input_queue
    import tpiq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int DESC_WIDTH  = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [31:0] descriptor_in
    input  wire logic [7:0]        s_tuser,   // [0] func, [2:1] push_kind

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [55:0]       m_tdata,   // [31:0] descriptor_out,
                                              // [42:32] high_fill, [53:43] low_fill
    output logic      [7:0]        m_tuser,   // [2:0] status, [3] from_high

    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam int STORE_W = (DESC_WIDTH < DESC_W) ? DESC_WIDTH : DESC_W;
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);

    logic [CFG_W-1:0] high_cap_reg;
    logic [CFG_W-1:0] low_cap_reg;

    logic             in_xfer;
    tpiq_func_t       func;
    tpiq_kind_t       kind;

    tpiq_qstat_t      hi_stat, lo_stat;
    logic [CW-1:0]    hi_count, lo_count;
    logic [STORE_W-1:0] hi_rdata, lo_rdata;

    logic             hi_push, lo_push, hi_pop, lo_pop;

    logic             valid_reg, valid_next;
    tpiq_status_t     status_reg, status_next;
    logic             from_high_reg, from_high_next;

    logic [DESC_W-1:0] desc_out;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_cap_reg <= CFG_RESET;
            low_cap_reg  <= CFG_RESET;
        end else if (cfg_wr_en) begin
            if (tpiq_reg_t'(cfg_index) == REG_HIGH_CAP) begin
                high_cap_reg <= cfg_wdata;
            end else begin
                low_cap_reg <= cfg_wdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request decode and arbitration
    // ------------------------------------------------------------------
    assign s_tready = aresetn && (!valid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign func     = tpiq_func_t'(s_tuser[0]);
    assign kind     = tpiq_kind_t'(s_tuser[2:1]);

    always_comb begin
        hi_push        = 1'b0;
        lo_push        = 1'b0;
        hi_pop         = 1'b0;
        lo_pop         = 1'b0;
        status_next    = ST_EMPTY;
        from_high_next = 1'b0;
        if (func == FUNC_PUSH) begin
            if (kind == KIND_NORMAL) begin
                if (lo_stat.full) begin
                    status_next = ST_RETRY_FULL;
                end else begin
                    lo_push     = in_xfer;
                    status_next = ST_ACCEPTED;
                end
            end else if (hi_stat.full) begin
                // resubmit and recirculate are dropped; a stop marker retries
                status_next = (kind == KIND_STOP) ? ST_RETRY_FULL : ST_DROPPED;
            end else begin
                hi_push     = in_xfer;
                status_next = ST_ACCEPTED;
            end
        end else begin
            priority if (hi_stat.held) begin
                hi_pop         = in_xfer;
                status_next    = ST_POPPED;
                from_high_next = 1'b1;
            end else if (lo_stat.held) begin
                lo_pop      = in_xfer;
                status_next = ST_POPPED;
            end else begin
                status_next = ST_EMPTY;
            end
        end
    end

    // ------------------------------------------------------------------
    // Queues
    // ------------------------------------------------------------------
    tpiq_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (STORE_W)
    ) u_high_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capacity  (high_cap_reg),
        .push_en   (hi_push),
        .push_data (s_tdata[STORE_W-1:0]),
        .pop_en    (hi_pop),
        .stat      (hi_stat),
        .count     (hi_count),
        .rdata     (hi_rdata)
    );

    tpiq_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (STORE_W)
    ) u_low_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capacity  (low_cap_reg),
        .push_en   (lo_push),
        .push_data (s_tdata[STORE_W-1:0]),
        .pop_en    (lo_pop),
        .stat      (lo_stat),
        .count     (lo_count),
        .rdata     (lo_rdata)
    );

    // ------------------------------------------------------------------
    // Result slot
    // ------------------------------------------------------------------
    always_comb begin
        valid_next = valid_reg;
        if (in_xfer) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            status_reg    <= status_next;
            from_high_reg <= from_high_next;
        end
    end

    // Counts and read data hold while the slot is full, so read them directly
    always_comb begin
        desc_out = '0;
        if (status_reg == ST_POPPED) begin
            desc_out = from_high_reg ? DESC_W'(hi_rdata) : DESC_W'(lo_rdata);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, FILL_W'(lo_count), FILL_W'(hi_count), desc_out};
    assign m_tuser  = {4'b0000, from_high_reg, status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(hi_count) <= QUEUE_DEPTH) && (int'(lo_count) <= QUEUE_DEPTH))
        else $error("queue fill beyond store depth");

    a_empty_means_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == ST_EMPTY) |-> (hi_count == '0 && lo_count == '0))
        else $error("empty status while a queue holds entries");

    a_high_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && func == FUNC_POP && hi_stat.held)
            |=> (m_tvalid && status_reg == ST_POPPED && from_high_reg))
        else $error("pop skipped a nonempty high queue");

    a_low_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        lo_push |=> (lo_count == $past(lo_count) + CW'(1)))
        else $error("low queue count did not advance on push");

endmodule

`default_nettype wire

FILE: tb/tb_two_priority_input_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_priority_input_queue: self-checking bench for the two priority queue
// Drives push and pop requests through the input stream. Random bursts and
// gaps on the input side and random stalls on the result side exercise the
// handshakes. Each result is checked field by field against a behavioral
// model of the two queues. A short directed part covers every packet kind,
// empty pops and full queues. A bulk phase runs the high queue past its
// capacity under an oversized low capacity and drains both queues.
// Random phases then run with changing capacities.
// ----------------------------------------------------------------------------
module tb_two_priority_input_queue
    import tpiq_pkg::*;
();

    localparam int DEPTH        = 1024;
    localparam int RESET_CYCLES = 11;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        tpiq_func_t        func;
        tpiq_kind_t        kind;
        logic [DESC_W-1:0] desc;
    } request_t;

    typedef struct {
        tpiq_status_t      status;
        logic [DESC_W-1:0] desc;
        logic              from_high;
        logic [FILL_W-1:0] high_fill;
        logic [FILL_W-1:0] low_fill;
    } outcome_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata   = '0;   // [31:0] descriptor_in
    logic [7:0]       s_tuser   = '0;   // [0] func, [2:1] push_kind
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [55:0]      m_tdata;          // [31:0] descriptor_out, [42:32] high_fill,
                                        // [53:43] low_fill
    logic [7:0]       m_tuser;          // [2:0] status, [3] from_high
    logic             cfg_wr_en = 1'b0;
    tpiq_reg_t        cfg_index = REG_HIGH_CAP;
    logic [CFG_W-1:0] cfg_wdata = '0;

    two_priority_input_queue DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Model of the two queues and their capacities
    logic [DESC_W-1:0] high_entries[$];
    logic [DESC_W-1:0] low_entries[$];
    logic [CFG_W-1:0]  high_cap = CFG_RESET;
    logic [CFG_W-1:0]  low_cap  = CFG_RESET;

    request_t pending_requests[$];
    outcome_t due_outcomes[$];

    int mismatches   = 0;
    int results_seen = 0;
    int holds_asked  = 0;
    int holds_done   = 0;

    function automatic bit queue_full(int fill, logic [CFG_W-1:0] cap);
        int limit;
        limit = (cap > DEPTH) ? DEPTH : int'(cap);
        return fill >= limit;
    endfunction

    function automatic outcome_t serve_request(request_t r);
        outcome_t o;
        o.status    = ST_ACCEPTED;
        o.desc      = '0;
        o.from_high = 1'b0;
        if (r.func == FUNC_PUSH) begin
            if (r.kind == KIND_NORMAL) begin
                if (queue_full(low_entries.size(), low_cap))
                    o.status = ST_RETRY_FULL;
                else
                    low_entries = {low_entries, r.desc};
            end else if (queue_full(high_entries.size(), high_cap)) begin
                // stop markers wait for room, resubmit and recirculate are lost
                o.status = (r.kind == KIND_STOP) ? ST_RETRY_FULL : ST_DROPPED;
            end else begin
                high_entries = {high_entries, r.desc};
            end
        end else if (high_entries.size() > 0) begin
            o.status    = ST_POPPED;
            o.desc      = high_entries.pop_front();
            o.from_high = 1'b1;
        end else if (low_entries.size() > 0) begin
            o.status = ST_POPPED;
            o.desc   = low_entries.pop_front();
        end else begin
            o.status = ST_EMPTY;
        end
        o.high_fill = FILL_W'(high_entries.size());
        o.low_fill  = FILL_W'(low_entries.size());
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t ns: result %0d %s got %0h expected %0h",
                 $time, results_seen, field, got, want);
        mismatches++;
    endtask

    // Sender: bursts of random length separated by random gaps
    request_t on_wire;
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                due_outcomes = {due_outcomes, serve_request(on_wire)};
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    on_wire = pending_requests.pop_front();
                    s_tdata  <= on_wire.desc;
                    s_tuser  <= {5'b0, on_wire.kind, on_wire.func};
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: rotating stall pattern, and a single long hold-off
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;
    int          hold_left     = 0;
    outcome_t    want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (due_outcomes.size() == 0) begin
                    report_mismatch("unexpected transfer, status", 32'(m_tuser[2:0]), '0);
                end else begin
                    want = due_outcomes.pop_front();
                    if (m_tuser[2:0] !== want.status)
                        report_mismatch("status", 32'(m_tuser[2:0]), 32'(want.status));
                    if (m_tdata[31:0] !== want.desc)
                        report_mismatch("descriptor_out", m_tdata[31:0], want.desc);
                    if (m_tuser[3] !== want.from_high)
                        report_mismatch("from_high", 32'(m_tuser[3]), 32'(want.from_high));
                    if (m_tdata[42:32] !== want.high_fill)
                        report_mismatch("high_fill", 32'(m_tdata[42:32]),
                                        32'(want.high_fill));
                    if (m_tdata[53:43] !== want.low_fill)
                        report_mismatch("low_fill", 32'(m_tdata[53:43]),
                                        32'(want.low_fill));
                end
            end
            if (holds_asked > holds_done) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (pattern_age == 0) begin
                pattern_age   = $urandom_range(32, 128);
                ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                            : (16'($urandom) | 16'h0001);
            end else begin
                pattern_age--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
        end
    end

    task automatic queue_request(tpiq_func_t f, tpiq_kind_t k, logic [DESC_W-1:0] d);
        request_t r;
        r.func = f;
        r.kind = k;
        r.desc = d;
        pending_requests = {pending_requests, r};
    endtask

    // Hold until every request has been sent and every result collected
    task automatic wait_idle();
        while (pending_requests.size() > 0 || s_tvalid || due_outcomes.size() > 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_capacity(tpiq_reg_t idx, logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_HIGH_CAP)
            high_cap = value;
        else
            low_cap = value;
    endtask

    function automatic logic [CFG_W-1:0] pick_capacity();
        case ($urandom_range(0, 6))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'($urandom_range(2, 8));
            3:       return 11'($urandom_range(9, 64));
            4:       return ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'd2047;
            5:       return 11'($urandom_range(2, 16));
            default: return 11'($urandom);
        endcase
    endfunction

    // Push-heavy and pop-heavy stretches so the queues both fill and drain
    task automatic random_traffic(int count);
        int push_pct;
        push_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 24 == 0)
                push_pct = $urandom_range(20, 85);
            if ($urandom_range(1, 100) <= push_pct)
                queue_request(FUNC_PUSH, tpiq_kind_t'($urandom_range(0, 3)), $urandom);
            else
                queue_request(FUNC_POP, tpiq_kind_t'($urandom_range(0, 3)), $urandom);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // every kind at reset capacity, high queue drains first
        queue_request(FUNC_POP,  KIND_NORMAL,      32'h0000_0000);
        queue_request(FUNC_PUSH, KIND_NORMAL,      32'h0000_0000);
        queue_request(FUNC_PUSH, KIND_NORMAL,      32'hFFFF_FFFF);
        queue_request(FUNC_PUSH, KIND_RESUBMIT,    32'h5A5A_A5A5);
        queue_request(FUNC_PUSH, KIND_RECIRCULATE, 32'h1234_5678);
        queue_request(FUNC_PUSH, KIND_STOP,        32'h8000_0001);
        repeat (6) queue_request(FUNC_POP, KIND_STOP, 32'hFFFF_FFFF);
        wait_idle();

        // zero capacity: both queues always full
        write_capacity(REG_HIGH_CAP, 11'd0);
        write_capacity(REG_LOW_CAP, 11'd0);
        queue_request(FUNC_PUSH, KIND_NORMAL,      32'hDEAD_0001);
        queue_request(FUNC_PUSH, KIND_RESUBMIT,    32'hDEAD_0002);
        queue_request(FUNC_PUSH, KIND_RECIRCULATE, 32'hDEAD_0003);
        queue_request(FUNC_PUSH, KIND_STOP,        32'hDEAD_0004);
        queue_request(FUNC_POP,  KIND_RESUBMIT,    32'h0);
        wait_idle();

        write_capacity(REG_HIGH_CAP, 11'd2);
        write_capacity(REG_LOW_CAP, 11'd1);
        queue_request(FUNC_PUSH, KIND_RESUBMIT,    32'hA000_0001);
        queue_request(FUNC_PUSH, KIND_RECIRCULATE, 32'hA000_0002);
        queue_request(FUNC_PUSH, KIND_RECIRCULATE, 32'hA000_0003);
        queue_request(FUNC_PUSH, KIND_STOP,        32'hA000_0004);
        queue_request(FUNC_PUSH, KIND_NORMAL,      32'hB000_0001);
        queue_request(FUNC_PUSH, KIND_NORMAL,      32'hB000_0002);
        wait_idle();

        // capacity lowered under the current fill: full until popped below
        write_capacity(REG_HIGH_CAP, 11'd1);
        queue_request(FUNC_PUSH, KIND_STOP,     32'hC000_0001);
        queue_request(FUNC_PUSH, KIND_RESUBMIT, 32'hC000_0002);
        queue_request(FUNC_POP,  KIND_NORMAL,   32'h0);
        queue_request(FUNC_POP,  KIND_NORMAL,   32'h0);
        queue_request(FUNC_POP,  KIND_NORMAL,   32'h0);
        queue_request(FUNC_POP,  KIND_NORMAL,   32'h0);
        wait_idle();

        // run the high queue one past its capacity while the low queue sits
        // under an oversized capacity, then drain both and pop them empty
        write_capacity(REG_HIGH_CAP, 11'd48);
        write_capacity(REG_LOW_CAP, 11'd2047);
        for (int i = 0; i <= 48; i++) begin
            queue_request(FUNC_PUSH, KIND_NORMAL, $urandom);
            queue_request(FUNC_PUSH, tpiq_kind_t'($urandom_range(1, 3)), $urandom);
        end
        for (int i = 0; i < 100; i++)
            queue_request(FUNC_POP, tpiq_kind_t'($urandom_range(0, 3)), $urandom);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_capacity(REG_HIGH_CAP, pick_capacity());
            write_capacity(REG_LOW_CAP, pick_capacity());
            random_traffic(120);
            if (p == 2)
                holds_asked++;
            wait_idle();
        end

        repeat (5) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t ns: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
